@@ sv/mlpd_pkg.sv @@
`default_nettype none

package mlpd_pkg;

   // defaults for the top level parameters
   localparam int unsigned MaxLevelsDef  = 6;
   localparam int unsigned AlarmTicksDef = 2000;
   localparam int unsigned TimerBitsDef  = 20;

   // fixed field widths
   localparam int unsigned NumThr   = 6;
   localparam int unsigned ThrW     = 20;
   localparam int unsigned LvlW     = 3;
   localparam int unsigned CntW     = 3;
   localparam int unsigned AlarmW   = 16;
   localparam int unsigned BeepW    = 10;
   localparam int unsigned DurW     = 20;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 20;

   localparam logic [BeepW-1:0] LevelBeepMs = 10'd200;
   localparam logic [BeepW-1:0] AlarmBeepMs = 10'd1000;
   localparam logic [DurW-1:0]  DurMax      = {DurW{1'b1}};

   localparam logic [CntW-1:0] LevelCountReset = 3'd1;
   localparam logic [NumThr-1:0][ThrW-1:0] ThrReset = {
      20'd5000, 20'd4000, 20'd3000, 20'd2000, 20'd1000, 20'd50
   };

   typedef enum logic [CsrIdxW-1:0] {
      CSR_POLARITY    = 3'd0,
      CSR_LEVEL_COUNT = 3'd1,
      CSR_THR1        = 3'd2,
      CSR_THR2        = 3'd3,
      CSR_THR3        = 3'd4,
      CSR_THR4        = 3'd5,
      CSR_THR5        = 3'd6,
      CSR_THR6        = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                        polarity;
      logic [CntW-1:0]             level_count;
      logic [NumThr-1:0][ThrW-1:0] thr;
   } cfg_type;

   // level decode results handed back to the top
   typedef struct packed {
      logic [LvlW-1:0] level;   // highest threshold reached
      logic [LvlW-1:0] n_used;  // levels in use after clipping
   } lvl_type;

endpackage

`default_nettype wire

@@ sv/mlpd_if.sv @@
`default_nettype none

interface mlpd_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface mlpd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           held;
   logic [mlpd_pkg::LvlW-1:0]      level;
   logic                           press_done;
   logic [mlpd_pkg::LvlW-1:0]      done_level;
   logic [mlpd_pkg::DurW-1:0]      done_duration;
   logic                           beep_request;
   logic [mlpd_pkg::BeepW-1:0]     beep_ms;

   modport source (output valid, output held, output level, output press_done,
                   output done_level, output done_duration, output beep_request,
                   output beep_ms, input ready);
   modport sink   (input valid, input held, input level, input press_done,
                   input done_level, input done_duration, input beep_request,
                   input beep_ms, output ready);
endinterface

`default_nettype wire

@@ sv/mlpd_level.sv @@
`default_nettype none

// Threshold compare and priority pick: highest level in use whose
// threshold the held time has reached.
module mlpd_level #(
   parameter int unsigned MAX_LEVELS = mlpd_pkg::MaxLevelsDef,
   parameter int unsigned TIMER_BITS = mlpd_pkg::TimerBitsDef
) (
   input  wire mlpd_pkg::cfg_type         cfg,
   input  wire logic [TIMER_BITS-1:0]     ticks,
   output mlpd_pkg::lvl_type              result
);

   localparam int unsigned CmpW = (TIMER_BITS > mlpd_pkg::ThrW) ? TIMER_BITS
                                                                : mlpd_pkg::ThrW;

   logic [mlpd_pkg::LvlW-1:0] n_used;
   logic [mlpd_pkg::LvlW-1:0] lvl;
   logic [CmpW-1:0]           ticks_x;

   always_comb begin
      if (cfg.level_count > mlpd_pkg::LvlW'(MAX_LEVELS)) begin
         n_used = mlpd_pkg::LvlW'(MAX_LEVELS);
      end else begin
         n_used = cfg.level_count;
      end
   end

   assign ticks_x = CmpW'(ticks);

   // ascending scan, the last hit is the highest index
   always_comb begin
      lvl = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if ((mlpd_pkg::LvlW'(i + 1) <= n_used) && (ticks_x >= CmpW'(cfg.thr[i]))) begin
            lvl = mlpd_pkg::LvlW'(i + 1);
         end
      end
   end

   assign result.level  = lvl;
   assign result.n_used = n_used;

endmodule

`default_nettype wire

@@ sv/multi_level_long_press_detector.sv @@
// Path: a word accepted into the input register moves on to the result register
// when that register is free or drained, and is then shown on rsp; one result
// word per input word. Throughput: one word per cycle while rsp is not stalled,
// set by the single compare/update pass.
// Reset (synchronous, active high): config back to defaults, press state
// cleared, alarm counter loaded so an alarm is due at once, both stages empty.
`default_nettype none

module multi_level_long_press_detector #(
   parameter int unsigned MAX_LEVELS  = mlpd_pkg::MaxLevelsDef,   // 1..6
   parameter int unsigned ALARM_TICKS = mlpd_pkg::AlarmTicksDef,  // 1..65535
   parameter int unsigned TIMER_BITS  = mlpd_pkg::TimerBitsDef    // 8..32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mlpd_req_if.sink                             req,
   mlpd_rsp_if.source                           rsp,
   input  wire logic                            csr_we,
   input  wire logic [mlpd_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [mlpd_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int unsigned CmpW = (TIMER_BITS > mlpd_pkg::ThrW) ? TIMER_BITS
                                                                : mlpd_pkg::ThrW;
   localparam logic [TIMER_BITS-1:0]       TimerMax = {TIMER_BITS{1'b1}};
   localparam logic [mlpd_pkg::AlarmW-1:0] AlarmMax = mlpd_pkg::AlarmW'(ALARM_TICKS);

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   mlpd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polarity    <= 1'b0;
         cfg_ff.level_count <= mlpd_pkg::LevelCountReset;
         cfg_ff.thr         <= mlpd_pkg::ThrReset;
      end else if (csr_we) begin
         unique case (mlpd_pkg::csr_idx_type'(csr_index))
            mlpd_pkg::CSR_POLARITY:    cfg_ff.polarity    <= csr_wdata[0];
            mlpd_pkg::CSR_LEVEL_COUNT: cfg_ff.level_count <= csr_wdata[mlpd_pkg::CntW-1:0];
            mlpd_pkg::CSR_THR1:        cfg_ff.thr[0]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            mlpd_pkg::CSR_THR2:        cfg_ff.thr[1]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            mlpd_pkg::CSR_THR3:        cfg_ff.thr[2]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            mlpd_pkg::CSR_THR4:        cfg_ff.thr[3]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            mlpd_pkg::CSR_THR5:        cfg_ff.thr[4]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            mlpd_pkg::CSR_THR6:        cfg_ff.thr[5]      <= csr_wdata[mlpd_pkg::ThrW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input register -> result register
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_pin_ff;
   logic rsp_valid_ff;
   logic s1_move;

   // stage 1 word moves on when the result register is free or drained
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_pin_ff <= req.pin_level;
      end
   end

   // ---------------------------------------------------------------
   // Press state
   // ---------------------------------------------------------------
   logic                           last_raw_ff;
   logic                           timing_ff;
   logic [TIMER_BITS-1:0]          ticks_ff;
   logic [mlpd_pkg::LvlW-1:0]      cur_ff;
   logic [mlpd_pkg::LvlW-1:0]      ann_ff;
   logic                           maxr_ff;
   logic [mlpd_pkg::AlarmW-1:0]    alarm_ff;

   logic                           timing_in;
   logic [TIMER_BITS-1:0]          ticks_in;
   logic [mlpd_pkg::LvlW-1:0]      cur_in;
   logic [mlpd_pkg::LvlW-1:0]      ann_in;
   logic                           maxr_in;
   logic [mlpd_pkg::AlarmW-1:0]    alarm_in;

   // intermediate values after the edge/timer step
   logic                           held_c;
   logic                           edge_c;
   logic [TIMER_BITS-1:0]          dur_c;
   logic [CmpW-1:0]                dur_x;
   logic [mlpd_pkg::LvlW-1:0]      cur_a;
   logic [mlpd_pkg::LvlW-1:0]      ann_a;
   logic                           maxr_a;
   logic [mlpd_pkg::AlarmW-1:0]    alarm_a;
   logic                           done_c;
   logic [mlpd_pkg::LvlW-1:0]      done_lvl_c;
   logic [mlpd_pkg::DurW-1:0]      done_dur_c;
   logic                           beep_c;
   logic [mlpd_pkg::BeepW-1:0]     beep_ms_c;
   mlpd_pkg::lvl_type              lvl_c;

   assign held_c = (s1_pin_ff == cfg_ff.polarity);
   assign edge_c = (s1_pin_ff != last_raw_ff);
   // duration of a press released now: held ticks plus the release tick
   assign dur_c  = (ticks_ff == TimerMax) ? ticks_ff : ticks_ff + 1'b1;
   assign dur_x  = CmpW'(dur_c);

   // edge detect, press timer, release report
   always_comb begin
      timing_in  = timing_ff;
      ticks_in   = ticks_ff;
      cur_a      = cur_ff;
      ann_a      = ann_ff;
      maxr_a     = maxr_ff;
      done_c     = 1'b0;
      done_lvl_c = '0;
      done_dur_c = '0;
      alarm_a    = (alarm_ff < AlarmMax) ? alarm_ff + 1'b1 : alarm_ff;

      if (edge_c) begin
         if (held_c) begin
            timing_in = 1'b1;
            ticks_in  = '0;
         end else if (timing_ff) begin
            timing_in = 1'b0;
            ticks_in  = '0;
            // short presses are dropped
            if (dur_x > CmpW'(cfg_ff.thr[0])) begin
               done_c     = 1'b1;
               done_lvl_c = cur_ff;
               done_dur_c = (dur_x > CmpW'(mlpd_pkg::DurMax)) ? mlpd_pkg::DurMax
                                                             : dur_x[mlpd_pkg::DurW-1:0];
            end
            cur_a  = '0;
            ann_a  = '0;
            maxr_a = 1'b0;
         end
      end else if (held_c && timing_ff && (ticks_ff != TimerMax)) begin
         ticks_in = ticks_ff + 1'b1;
      end
   end

   mlpd_level #(
      .MAX_LEVELS (MAX_LEVELS),
      .TIMER_BITS (TIMER_BITS)
   ) u_level (
      .cfg    (cfg_ff),
      .ticks  (ticks_in),
      .result (lvl_c)
   );

   // level ratchet, announcement and alarm beeps
   always_comb begin
      cur_in    = cur_a;
      maxr_in   = maxr_a;
      ann_in    = ann_a;
      alarm_in  = alarm_a;
      beep_c    = 1'b0;
      beep_ms_c = '0;

      if (held_c && timing_in) begin
         if (lvl_c.level > cur_a) begin
            cur_in = lvl_c.level;
         end
         if ((lvl_c.n_used != '0) && (cur_in == lvl_c.n_used)) begin
            maxr_in = 1'b1;
         end
      end

      if (held_c) begin
         if (cur_in != '0) begin
            if (cur_in != ann_a) begin
               beep_c    = 1'b1;
               beep_ms_c = mlpd_pkg::LevelBeepMs;
               ann_in    = cur_in;
            end
            // alarm wins a collision; the new level still counts as announced
            if (maxr_in && (alarm_a >= AlarmMax)) begin
               beep_c    = 1'b1;
               beep_ms_c = mlpd_pkg::AlarmBeepMs;
               alarm_in  = '0;
            end
         end
      end else begin
         ann_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         timing_ff   <= 1'b0;
         ticks_ff    <= '0;
         cur_ff      <= '0;
         ann_ff      <= '0;
         maxr_ff     <= 1'b0;
         alarm_ff    <= AlarmMax;
      end else if (s1_move) begin
         last_raw_ff <= s1_pin_ff;
         timing_ff   <= timing_in;
         ticks_ff    <= ticks_in;
         cur_ff      <= cur_in;
         ann_ff      <= ann_in;
         maxr_ff     <= maxr_in;
         alarm_ff    <= alarm_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic                           held_ff;
   logic [mlpd_pkg::LvlW-1:0]      level_ff;
   logic                           done_ff;
   logic [mlpd_pkg::LvlW-1:0]      done_lvl_ff;
   logic [mlpd_pkg::DurW-1:0]      done_dur_ff;
   logic                           beep_ff;
   logic [mlpd_pkg::BeepW-1:0]     beep_ms_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         held_ff     <= held_c;
         level_ff    <= cur_in;
         done_ff     <= done_c;
         done_lvl_ff <= done_lvl_c;
         done_dur_ff <= done_dur_c;
         beep_ff     <= beep_c;
         beep_ms_ff  <= beep_ms_c;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.held          = held_ff;
   assign rsp.level         = level_ff;
   assign rsp.press_done    = done_ff;
   assign rsp.done_level    = done_lvl_ff;
   assign rsp.done_duration = done_dur_ff;
   assign rsp.beep_request  = beep_ff;
   assign rsp.beep_ms       = beep_ms_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_move && done_c) |=> (cur_ff == '0) && !timing_ff && !maxr_ff)
      else $error("levels not cleared after a reported press");

   a_not_held_unannounced: assert property (@(posedge clock) disable iff (reset)
      (s1_move && !held_c) |=> (ann_ff == '0))
      else $error("announced level kept across release");

   a_beep_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (beep_ff == (beep_ms_ff != '0)))
      else $error("beep request and beep length disagree");

   a_alarm_bound: assert property (@(posedge clock) disable iff (reset)
      alarm_ff <= AlarmMax)
      else $error("alarm counter past its limit");

   a_max_has_level: assert property (@(posedge clock) disable iff (reset)
      maxr_ff |-> (cur_ff != '0))
      else $error("top level flagged without a level");

endmodule

`default_nettype wire
